FILE: rtl/cems_pkg.sv
package cems_pkg;

   localparam int DT_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int LIMIT_BITS = 31;
   localparam int NUM_AXES = 3;
   localparam int IDX_BITS = 2;
   localparam int CNT_BITS = 5;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 31;
   localparam int PROD_BITS = 66;

   localparam logic [DT_BITS-1:0] STEP_TIME_RESET = 16'd1092;
   localparam logic [LIMIT_BITS-1:0] VEL_LIMIT_RESET = 31'd65536;

   localparam logic CSR_STEP_TIME = 1'b0;
   localparam logic CSR_VEL_LIMIT = 1'b1;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_STEP = 2'd1;
   localparam logic [1:0] MODE_LOAD = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCUM,
      OP_LOAD,
      OP_MUL_FDT,
      OP_VEL_ADD,
      OP_MUL_VSQ,
      OP_SUM_ACC,
      OP_MUL_CAP,
      OP_CAP_SET,
      OP_MUL_CAPSQ,
      OP_COMPARE,
      OP_SQRT_STEP,
      OP_SQRT_DONE,
      OP_MUL_MCAP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_VEL_SET,
      OP_MUL_VDT,
      OP_POS_ADD,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic [IDX_BITS-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic capped;
   } status_type;

   function automatic logic signed [WORD_BITS-1:0] sat32(input logic signed [WORD_BITS+1:0] v);
      logic signed [WORD_BITS-1:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/cems_dp.sv
module cems_dp (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic csr_index,
   input  logic [cems_pkg::LIMIT_BITS-1:0] csr_data,
   input  logic [3*cems_pkg::WORD_BITS-1:0] req_tdata,
   input  cems_pkg::cmd_type cmd,
   output cems_pkg::status_type status,
   output logic [6*cems_pkg::WORD_BITS-1:0] rsp_tdata,
   output logic rsp_tuser
);

   logic signed [31:0] pos_ff [cems_pkg::NUM_AXES];
   logic signed [31:0] pos_in [cems_pkg::NUM_AXES];
   logic signed [31:0] vel_ff [cems_pkg::NUM_AXES];
   logic signed [31:0] vel_in [cems_pkg::NUM_AXES];
   logic signed [31:0] frc_ff [cems_pkg::NUM_AXES];
   logic signed [31:0] frc_in [cems_pkg::NUM_AXES];
   logic signed [31:0] val [cems_pkg::NUM_AXES];
   logic [15:0] dt_ff, dt_in;
   logic [30:0] vlim_ff, vlim_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [63:0] sumsq_ff, sumsq_in;
   logic [30:0] cap_ff, cap_in;
   logic capped_ff, capped_in;
   logic [63:0] rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in, trial;
   logic [31:0] len_ff, len_in, drem_ff, drem_in;
   logic [30:0] dlow_ff, dlow_in, quot_ff, quot_in;
   logic [32:0] rem_sh, diff;
   logic [191:0] out_ff, out_in;
   logic out_cap_ff, out_cap_in;
   logic signed [32:0] mul_a, mul_b, vabs, shifted;
   logic signed [31:0] vsel, psel, fsel, qval;

   always_comb begin
      for (int i = 0; i < cems_pkg::NUM_AXES; i++) begin
         val[i] = req_tdata[32*i +: 32];
      end
      vsel = vel_ff[cmd.idx];
      psel = pos_ff[cmd.idx];
      fsel = frc_ff[cmd.idx];
      vabs = vsel[31] ? -{vsel[31], vsel} : {vsel[31], vsel};
      shifted = prod_ff[48:16];
      trial = res_ff + bit_ff;
      rem_sh = {drem_ff, dlow_ff[30]};
      diff = rem_sh - {1'b0, len_ff};
      qval = {1'b0, quot_ff};
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         cems_pkg::OP_MUL_FDT: begin
            mul_a = {fsel[31], fsel};
            mul_b = {17'd0, dt_ff};
         end
         cems_pkg::OP_MUL_VSQ: begin
            mul_a = vabs;
            mul_b = vabs;
         end
         cems_pkg::OP_MUL_CAP: begin
            mul_a = {2'd0, vlim_ff};
            mul_b = {17'd0, dt_ff};
         end
         cems_pkg::OP_MUL_CAPSQ: begin
            mul_a = {2'd0, cap_ff};
            mul_b = {2'd0, cap_ff};
         end
         cems_pkg::OP_MUL_MCAP: begin
            mul_a = vabs;
            mul_b = {2'd0, cap_ff};
         end
         cems_pkg::OP_MUL_VDT: begin
            mul_a = {vsel[31], vsel};
            mul_b = {17'd0, dt_ff};
         end
         default: begin
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      pos_in = pos_ff;
      vel_in = vel_ff;
      frc_in = frc_ff;
      dt_in = dt_ff;
      vlim_in = vlim_ff;
      sumsq_in = sumsq_ff;
      cap_in = cap_ff;
      capped_in = capped_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      len_in = len_ff;
      drem_in = drem_ff;
      dlow_in = dlow_ff;
      quot_in = quot_ff;
      out_in = out_ff;
      out_cap_in = out_cap_ff;
      if (csr_valid) begin
         case (csr_index)
            cems_pkg::CSR_STEP_TIME: dt_in = csr_data[15:0];
            cems_pkg::CSR_VEL_LIMIT: vlim_in = csr_data;
            default: begin
            end
         endcase
      end
      case (cmd.op)
         cems_pkg::OP_ACCUM: begin
            for (int i = 0; i < cems_pkg::NUM_AXES; i++) begin
               frc_in[i] = cems_pkg::sat32({{2{frc_ff[i][31]}}, frc_ff[i]}
                                           + {{2{val[i][31]}}, val[i]});
            end
            sumsq_in = '0;
         end
         cems_pkg::OP_LOAD: begin
            for (int i = 0; i < cems_pkg::NUM_AXES; i++) begin
               pos_in[i] = val[i];
               vel_in[i] = '0;
               frc_in[i] = '0;
            end
         end
         cems_pkg::OP_VEL_ADD: begin
            vel_in[cmd.idx] = cems_pkg::sat32({{2{vsel[31]}}, vsel} + {shifted[32], shifted});
         end
         cems_pkg::OP_SUM_ACC: sumsq_in = sumsq_ff + prod_ff[63:0];
         cems_pkg::OP_CAP_SET: cap_in = prod_ff[46:16];
         cems_pkg::OP_COMPARE: begin
            capped_in = sumsq_ff > prod_ff[63:0];
            rem_in = sumsq_ff;
            res_in = '0;
            bit_in = 64'h4000_0000_0000_0000;
         end
         cems_pkg::OP_SQRT_STEP: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         cems_pkg::OP_SQRT_DONE: len_in = (res_ff == '0) ? 32'd1 : res_ff[31:0];
         cems_pkg::OP_DIV_INIT: begin
            drem_in = {1'b0, prod_ff[61:31]};
            dlow_in = prod_ff[30:0];
            quot_in = '0;
         end
         cems_pkg::OP_DIV_STEP: begin
            if (!diff[32]) begin
               drem_in = diff[31:0];
            end else begin
               drem_in = rem_sh[31:0];
            end
            quot_in = {quot_ff[29:0], !diff[32]};
            dlow_in = {dlow_ff[29:0], 1'b0};
         end
         cems_pkg::OP_VEL_SET: vel_in[cmd.idx] = vsel[31] ? -qval : qval;
         cems_pkg::OP_POS_ADD: begin
            pos_in[cmd.idx] = cems_pkg::sat32({{2{psel[31]}}, psel} + {shifted[32], shifted});
         end
         cems_pkg::OP_EMIT: begin
            out_in = {vel_ff[2], vel_ff[1], vel_ff[0], pos_ff[2], pos_ff[1], pos_ff[0]};
            out_cap_in = capped_ff;
            for (int i = 0; i < cems_pkg::NUM_AXES; i++) begin
               frc_in[i] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cems_pkg::NUM_AXES; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            frc_ff[i] <= '0;
         end
         dt_ff <= cems_pkg::STEP_TIME_RESET;
         vlim_ff <= cems_pkg::VEL_LIMIT_RESET;
         capped_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         frc_ff <= frc_in;
         dt_ff <= dt_in;
         vlim_ff <= vlim_in;
         capped_ff <= capped_in;
      end
      prod_ff <= prod_in;
      sumsq_ff <= sumsq_in;
      cap_ff <= cap_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      len_ff <= len_in;
      drem_ff <= drem_in;
      dlow_ff <= dlow_in;
      quot_ff <= quot_in;
      out_ff <= out_in;
      out_cap_ff <= out_cap_in;
   end

   assign status.capped = capped_ff;
   assign rsp_tdata = out_ff;
   assign rsp_tuser = out_cap_ff;

   a_quot_within_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.op == cems_pkg::OP_VEL_SET |-> quot_ff <= cap_ff)
      else $error("rescaled magnitude exceeds the cap");

   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.op == cems_pkg::OP_SQRT_DONE |-> res_ff[63:32] == '0)
      else $error("square root wider than 32 bits");

   a_capped_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.op == cems_pkg::OP_SQRT_DONE && capped_ff |-> res_ff != '0)
      else $error("capped velocity with zero length");

endmodule

FILE: rtl/cems_ctrl.sv
module cems_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  cems_pkg::status_type status,
   output cems_pkg::cmd_type cmd
);

   typedef enum logic [17:0] {
      S_IDLE      = 18'h00001,
      S_FDT_MUL   = 18'h00002,
      S_VEL_ADD   = 18'h00004,
      S_VSQ_MUL   = 18'h00008,
      S_SUM_ACC   = 18'h00010,
      S_CAP_MUL   = 18'h00020,
      S_CAP_SET   = 18'h00040,
      S_CAPSQ_MUL = 18'h00080,
      S_COMPARE   = 18'h00100,
      S_SQRT      = 18'h00200,
      S_SQRT_DONE = 18'h00400,
      S_MCAP_MUL  = 18'h00800,
      S_DIV_INIT  = 18'h01000,
      S_DIV       = 18'h02000,
      S_VEL_SET   = 18'h04000,
      S_VDT_MUL   = 18'h08000,
      S_POS_ADD   = 18'h10000,
      S_EMIT      = 18'h20000
   } state_type;

   state_type state_ff, state_in;
   logic [cems_pkg::IDX_BITS-1:0] idx_ff, idx_in;
   logic [cems_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic valid_ff, valid_in;
   logic last_axis;

   assign last_axis = idx_ff == 2'(cems_pkg::NUM_AXES - 1);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd.op = cems_pkg::OP_NONE;
      cmd.idx = idx_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_tuser)
                  cems_pkg::MODE_ADD: cmd.op = cems_pkg::OP_ACCUM;
                  cems_pkg::MODE_STEP: begin
                     cmd.op = cems_pkg::OP_ACCUM;
                     idx_in = '0;
                     state_in = S_FDT_MUL;
                  end
                  cems_pkg::MODE_LOAD: cmd.op = cems_pkg::OP_LOAD;
                  default: begin
                  end
               endcase
            end
         end
         S_FDT_MUL: begin
            cmd.op = cems_pkg::OP_MUL_FDT;
            state_in = S_VEL_ADD;
         end
         S_VEL_ADD: begin
            cmd.op = cems_pkg::OP_VEL_ADD;
            state_in = S_VSQ_MUL;
         end
         S_VSQ_MUL: begin
            cmd.op = cems_pkg::OP_MUL_VSQ;
            state_in = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            cmd.op = cems_pkg::OP_SUM_ACC;
            if (last_axis) begin
               idx_in = '0;
               state_in = S_CAP_MUL;
            end else begin
               idx_in = idx_ff + 2'd1;
               state_in = S_FDT_MUL;
            end
         end
         S_CAP_MUL: begin
            cmd.op = cems_pkg::OP_MUL_CAP;
            state_in = S_CAP_SET;
         end
         S_CAP_SET: begin
            cmd.op = cems_pkg::OP_CAP_SET;
            state_in = S_CAPSQ_MUL;
         end
         S_CAPSQ_MUL: begin
            cmd.op = cems_pkg::OP_MUL_CAPSQ;
            state_in = S_COMPARE;
         end
         S_COMPARE: begin
            cmd.op = cems_pkg::OP_COMPARE;
            cnt_in = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (!status.capped) begin
               idx_in = '0;
               state_in = S_VDT_MUL;
            end else begin
               cmd.op = cems_pkg::OP_SQRT_STEP;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'(cems_pkg::SQRT_STEPS - 1)) begin
                  state_in = S_SQRT_DONE;
               end
            end
         end
         S_SQRT_DONE: begin
            cmd.op = cems_pkg::OP_SQRT_DONE;
            idx_in = '0;
            state_in = S_MCAP_MUL;
         end
         S_MCAP_MUL: begin
            cmd.op = cems_pkg::OP_MUL_MCAP;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op = cems_pkg::OP_DIV_INIT;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = cems_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(cems_pkg::DIV_STEPS - 1)) begin
               state_in = S_VEL_SET;
            end
         end
         S_VEL_SET: begin
            cmd.op = cems_pkg::OP_VEL_SET;
            if (last_axis) begin
               idx_in = '0;
               state_in = S_VDT_MUL;
            end else begin
               idx_in = idx_ff + 2'd1;
               state_in = S_MCAP_MUL;
            end
         end
         S_VDT_MUL: begin
            cmd.op = cems_pkg::OP_MUL_VDT;
            state_in = S_POS_ADD;
         end
         S_POS_ADD: begin
            cmd.op = cems_pkg::OP_POS_ADD;
            if (last_axis) begin
               state_in = S_EMIT;
            end else begin
               idx_in = idx_ff + 2'd1;
               state_in = S_VDT_MUL;
            end
         end
         S_EMIT: begin
            if (!valid_ff || rsp_tready) begin
               cmd.op = cems_pkg::OP_EMIT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         cnt_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd3)
      else $error("axis index out of range");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff < 5'(cems_pkg::DIV_STEPS))
      else $error("division ran too long");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == cems_pkg::OP_EMIT |=> rsp_tvalid)
      else $error("result not presented after emit");

endmodule

FILE: rtl/capped_euler_mass_step_top.sv
// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   tdata value x,y,z; tuser mode
// rsp       out        rsp_tvalid/rsp_tready   tdata pos x,y,z, vel x,y,z; tuser capped
// csr       in         csr_valid/csr_ready     csr_index, csr_data
//
// Force and load requests are applied without leaving the idle state. A step request
// runs the 32-step square root and the three 31-step divisions only when capped,
// using the shared multiplier and divider.
// Reset is synchronous and active high and restores the register defaults.
// A finished result waits in its output register while the next request is taken;
// a following step stalls only when it must emit over an untaken result.
module capped_euler_mass_step_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [95:0] req_tdata,  // value_x, value_y, value_z
   input  logic [1:0] req_tuser,   // mode
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [191:0] rsp_tdata, // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   output logic rsp_tuser,         // capped
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [30:0] csr_data
);

   cems_pkg::cmd_type cmd;
   cems_pkg::status_type status;

   assign csr_ready = 1'b1;

   cems_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status(status),
      .cmd(cmd)
   );

   cems_dp u_dp (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_tdata(req_tdata),
      .cmd(cmd),
      .status(status),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

endmodule
